// File: src/fcds_pkg.sv
`default_nettype none
package fcds_pkg;

  localparam int ChannelCount = 4;
  localparam int FifoBurstWords = 4;

  typedef enum logic [2:0] {
    CMD_SRC   = 3'd0,
    CMD_DST   = 3'd1,
    CMD_CNT   = 3'd2,
    CMD_CTL   = 3'd3,
    CMD_TRIG  = 3'd4,
    CMD_ADV   = 3'd5,
    CMD_RSV6  = 3'd6,
    CMD_RSV7  = 3'd7
  } cmd_t;

  localparam logic [2:0] TRIG_IMM   = 3'd0;
  localparam logic [2:0] TRIG_SPEC  = 3'd3;
  localparam logic [2:0] TRIG_FIFOA = 3'd4;
  localparam logic [2:0] TRIG_FIFOB = 3'd5;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_MEM   = 2'd1;
  localparam logic [1:0] MODE_FIFOA = 2'd2;
  localparam logic [1:0] MODE_FIFOB = 2'd3;

  localparam logic [1:0] STEP_INC    = 2'd0;
  localparam logic [1:0] STEP_DEC    = 2'd1;
  localparam logic [1:0] STEP_FIXED  = 2'd2;
  localparam logic [1:0] STEP_RELOAD = 2'd3;

  localparam logic [15:0] CTL_MASK   = 16'hF7E0;
  localparam logic [15:0] DRQ_BIT    = 16'h0800;
  localparam logic [31:0] FIFO_A_ADDR = 32'h040000A0;
  localparam logic [31:0] FIFO_B_ADDR = 32'h040000A4;
  localparam logic [31:0] ADDR27_MASK = 32'h07FFFFFF;
  localparam logic [31:0] ADDR28_MASK = 32'h0FFFFFFF;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  channel;
    logic [31:0] write_data;
    logic [2:0]  trigger_kind;
  } in_item_t;

  typedef struct packed {
    logic        transfer_valid;
    logic [1:0]  out_channel;
    logic [27:0] read_address;
    logic [31:0] write_address;
    logic        word_unit;
    logic        last_unit;
    logic        irq_request;
    logic        unsupported;
    logic [1:0]  fifo_target;
    logic        imm_waiting;
  } out_item_t;

  function automatic logic [31:0] step_addr(logic [31:0] a, logic [1:0] ctl, logic [2:0] size);
    case (ctl)
      STEP_DEC:   return a - {29'd0, size};
      STEP_FIXED: return a;
      default:    return a + {29'd0, size};
    endcase
  endfunction

  function automatic logic [16:0] full_count(logic [15:0] cnt, logic is3);
    logic [16:0] n;
    n = is3 ? {1'b0, cnt} : {3'b0, cnt[13:0]};
    if (n == 17'd0) n = is3 ? 17'h10000 : 17'h04000;
    return n;
  endfunction

endpackage
`default_nettype wire

// File: src/fcds_core.sv
`default_nettype none
module fcds_core
  import fcds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      go,
  input  wire in_item_t  item,
  output out_item_t      res,
  output logic           res_en
);

  logic [31:0] source_start [4];
  logic [31:0] dest_start [4];
  logic [15:0] count_start [4];
  logic [15:0] control_word [4];
  logic [31:0] source_now [4];
  logic [31:0] dest_now [4];
  logic [16:0] units_left [4];
  logic [1:0]  armed_mode [4];
  logic [1:0]  burst_position [4];
  logic        immediate_flag;

  logic [31:0] source_start_next [4];
  logic [31:0] dest_start_next [4];
  logic [15:0] count_start_next [4];
  logic [15:0] control_word_next [4];
  logic [31:0] source_now_next [4];
  logic [31:0] dest_now_next [4];
  logic [16:0] units_left_next [4];
  logic [1:0]  armed_mode_next [4];
  logic [1:0]  burst_position_next [4];
  logic        immediate_flag_next;

  always_comb begin
    logic [1:0]  c;
    logic        found, stop, was_en, was_imm, en, word, rep, imm_any;
    logic [2:0]  size;
    logic [31:0] addr, smask, dmask;
    logic [1:0]  sctl;
    logic [3:0]  sreg;
    logic [16:0] rem;
    logic [2:0]  bp;
    logic        dis;
    for (int i = 0; i < 4; i++) begin
      source_start_next[i] = source_start[i];
      dest_start_next[i] = dest_start[i];
      count_start_next[i] = count_start[i];
      control_word_next[i] = control_word[i];
      source_now_next[i] = source_now[i];
      dest_now_next[i] = dest_now[i];
      units_left_next[i] = units_left[i];
      armed_mode_next[i] = armed_mode[i];
      burst_position_next[i] = burst_position[i];
    end
    immediate_flag_next = immediate_flag;
    res = '0;
    res_en = 1'b0;
    c = item.channel;
    found = 1'b0; stop = 1'b0; dis = 1'b0;
    was_en = 1'b0; was_imm = 1'b0; en = 1'b0; word = 1'b0; rep = 1'b0;
    size = 3'd0; addr = '0; smask = '0; dmask = '0; sctl = '0; sreg = '0;
    rem = '0; bp = '0; imm_any = 1'b0;
    if (go) begin
      case (cmd_t'(item.command))
        CMD_SRC: source_start_next[c] = item.write_data;
        CMD_DST: dest_start_next[c] = item.write_data;
        CMD_CNT: count_start_next[c] = item.write_data[15:0];
        CMD_CTL: begin
          res_en = 1'b1;
          was_en = control_word[c][15];
          was_imm = was_en && control_word[c][13:12] == 2'd0;
          control_word_next[c] = item.write_data[15:0] &
            (CTL_MASK | ((c == 2'd3) ? DRQ_BIT : 16'h0000));
          en = control_word_next[c][15];
          if (!was_en && en) begin
            source_now_next[c] = source_start[c];
            dest_now_next[c] = dest_start[c];
            units_left_next[c] = full_count(count_start[c], c == 2'd3);
          end
          if (!en) begin
            units_left_next[c] = '0;
            armed_mode_next[c] = MODE_IDLE;
            burst_position_next[c] = '0;
          end
          if (en && control_word_next[c][13:12] == 2'd0) immediate_flag_next = 1'b1;
          else if (was_imm) begin
            for (int i = 0; i < 4; i++)
              if (control_word_next[i][15] && control_word_next[i][13:12] == 2'd0)
                imm_any = 1'b1;
            immediate_flag_next = imm_any;
          end
        end
        CMD_TRIG: begin
          res_en = 1'b1;
          if (item.trigger_kind <= TRIG_SPEC) begin
            for (int i = 0; i < 4; i++)
              if (!stop && control_word[i][15] &&
                  {1'b0, control_word[i][13:12]} == item.trigger_kind &&
                  armed_mode[i] == MODE_IDLE) begin
                if (control_word[i][8:7] == STEP_RELOAD) begin
                  stop = 1'b1;
                  if (item.trigger_kind == TRIG_IMM) immediate_flag_next = 1'b1;
                end else armed_mode_next[i] = MODE_MEM;
              end
            res.unsupported = stop;
          end else if (item.trigger_kind == TRIG_FIFOA || item.trigger_kind == TRIG_FIFOB) begin
            addr = (item.trigger_kind == TRIG_FIFOB) ? FIFO_B_ADDR : FIFO_A_ADDR;
            for (int i = 1; i <= 2; i++)
              if (!stop && control_word[i][15] && control_word[i][13:12] == 2'd3 &&
                  dest_start[i] == addr && armed_mode[i] == MODE_IDLE) begin
                if (!control_word[i][10] || control_word[i][8:7] == STEP_RELOAD ||
                    control_word[i][6:5] != STEP_FIXED)
                  stop = 1'b1;
                else begin
                  armed_mode_next[i] = (item.trigger_kind == TRIG_FIFOB) ? MODE_FIFOB
                                                                         : MODE_FIFOA;
                  burst_position_next[i] = '0;
                end
              end
            res.unsupported = stop;
          end else res.unsupported = 1'b1;
        end
        CMD_ADV: begin
          res_en = 1'b1;
          for (int i = 3; i >= 0; i--)
            if (armed_mode[i] != MODE_IDLE) begin
              found = 1'b1;
              c = 2'(i);
            end
          if (found) begin
            smask = (c == 2'd0) ? ADDR27_MASK : ADDR28_MASK;
            word = control_word[c][10];
            rep = control_word[c][9];
            res.transfer_valid = 1'b1;
            res.out_channel = c;
            if (armed_mode[c] == MODE_MEM) begin
              size = word ? 3'd4 : 3'd2;
              dmask = (c == 2'd3) ? ADDR28_MASK : ADDR27_MASK;
              sreg = source_now[c][27:24];
              sctl = (c != 2'd0 && sreg >= 4'd8 && sreg <= 4'hD) ? STEP_INC
                                                                  : control_word[c][8:7];
              addr = (source_now[c] & smask) & ~{29'd0, size - 3'd1};
              res.read_address = addr[27:0];
              res.write_address = (dest_now[c] & dmask) & ~{29'd0, size - 3'd1};
              res.word_unit = word;
              source_now_next[c] = step_addr(source_now[c], sctl, size);
              dest_now_next[c] = step_addr(dest_now[c], control_word[c][6:5], size);
              units_left_next[c] = (units_left[c] > 17'd1) ? units_left[c] - 17'd1 : '0;
              if (units_left[c] <= 17'd1) begin
                res.last_unit = 1'b1;
                res.irq_request = control_word[c][14];
                if (rep && control_word[c][13:12] != 2'd0) begin
                  units_left_next[c] = full_count(count_start[c], c == 2'd3);
                  if (control_word[c][6:5] == STEP_RELOAD) dest_now_next[c] = dest_start[c];
                  armed_mode_next[c] = MODE_IDLE;
                end else dis = 1'b1;
              end
            end else begin
              addr = (source_now[c] & smask) & ~32'd3;
              res.read_address = addr[27:0];
              res.write_address = (armed_mode[c] == MODE_FIFOB) ? FIFO_B_ADDR : FIFO_A_ADDR;
              res.word_unit = 1'b1;
              res.fifo_target = (armed_mode[c] == MODE_FIFOB) ? 2'd2 : 2'd1;
              source_now_next[c] = step_addr(source_now[c], control_word[c][8:7], 3'd4);
              bp = {1'b0, burst_position[c]} + 3'd1;
              burst_position_next[c] = bp[1:0];
              if (bp >= 3'(FifoBurstWords)) begin
                rem = (units_left[c] >= 17'(FifoBurstWords))
                      ? units_left[c] - 17'(FifoBurstWords) : '0;
                res.last_unit = 1'b1;
                dest_now_next[c] = dest_start[c];
                armed_mode_next[c] = MODE_IDLE;
                burst_position_next[c] = '0;
                if (rem != '0) units_left_next[c] = rem;
                else begin
                  res.irq_request = control_word[c][14];
                  if (rep) units_left_next[c] = full_count(count_start[c], c == 2'd3);
                  else dis = 1'b1;
                end
              end
            end
            if (dis) begin
              control_word_next[c][15] = 1'b0;
              units_left_next[c] = '0;
              armed_mode_next[c] = MODE_IDLE;
              burst_position_next[c] = '0;
              for (int i = 0; i < 4; i++)
                if (control_word_next[i][15] && control_word_next[i][13:12] == 2'd0)
                  imm_any = 1'b1;
              immediate_flag_next = imm_any;
            end
          end
        end
        default: ;
      endcase
    end
    res.imm_waiting = immediate_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        source_start[i] <= '0;
        dest_start[i] <= '0;
        count_start[i] <= '0;
        control_word[i] <= '0;
        source_now[i] <= '0;
        dest_now[i] <= '0;
        units_left[i] <= '0;
        armed_mode[i] <= MODE_IDLE;
        burst_position[i] <= '0;
      end
      immediate_flag <= 1'b0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        source_start[i] <= source_start_next[i];
        dest_start[i] <= dest_start_next[i];
        count_start[i] <= count_start_next[i];
        control_word[i] <= control_word_next[i];
        source_now[i] <= source_now_next[i];
        dest_now[i] <= dest_now_next[i];
        units_left[i] <= units_left_next[i];
        armed_mode[i] <= armed_mode_next[i];
        burst_position[i] <= burst_position_next[i];
      end
      immediate_flag <= immediate_flag_next;
    end
  end

`ifndef SYNTHESIS
  // a disarmed channel never keeps a burst count
  a_burst_idle: assert property (@(posedge clk) disable iff (rst)
    armed_mode[1] == MODE_IDLE |-> burst_position[1] == 2'd0)
    else $error("burst position without armed fifo");
  a_ch0_no_fifo: assert property (@(posedge clk) disable iff (rst)
    armed_mode[0] == MODE_IDLE || armed_mode[0] == MODE_MEM)
    else $error("channel 0 in fifo mode");
  a_disarmed_off: assert property (@(posedge clk) disable iff (rst)
    !control_word[2][15] |-> armed_mode[2] == MODE_IDLE)
    else $error("disabled channel armed");
`endif

endmodule
`default_nettype wire

// File: src/four_channel_dma_sequencer.sv
`default_nettype none
// channel  direction  handshake          payload
// in       input      in_valid/in_ready   in_item  (in_item_t)
// out      output     out_valid/out_ready out_item (out_item_t)
// one item per cycle unless out stalls; items go through the channel state update logic
// a result lands in the output register the cycle after its item is accepted
// reset is synchronous, active high, and clears all channel state
// out stalls hold the output register; in_ready stays high while it is empty or being taken
module four_channel_dma_sequencer
  import fcds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic      go;
  logic      res_en;
  out_item_t res;

  assign in_ready = !out_valid || out_ready;
  assign go = in_valid && in_ready;

  fcds_core u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (in_item),
    .res    (res),
    .res_en (res_en)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= res_en;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && res_en) begin
      out_item <= res;
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item lost under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  a_xfer: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.fifo_target != 2'd0 |-> out_item.word_unit)
    else $error("fifo unit not word sized");
`endif

endmodule
`default_nettype wire

// File: tb/sv/fcds_checker.sv
`timescale 1ns / 100ps
module fcds_checker
  import fcds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire in_item_t  in_item,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire out_item_t out_item,
  output int             errors,
  output int             pending
);

  localparam logic [15:0] REPEAT_BIT = 16'h0200;
  localparam logic [15:0] WORD_BIT   = 16'h0400;
  localparam logic [15:0] IRQ_BIT    = 16'h4000;
  localparam logic [15:0] ENABLE_BIT = 16'h8000;

  logic [31:0] src_start [4];
  logic [31:0] dst_start [4];
  logic [15:0] cnt_start [4];
  logic [15:0] ctl_word [4];
  logic [31:0] src_now [4];
  logic [31:0] dst_now [4];
  int unsigned units_left [4];
  logic [1:0]  armed [4];
  int unsigned burst_pos [4];
  bit          imm_flag;

  out_item_t expected_units [$];

  function automatic logic [1:0] timing(int c);
    return ctl_word[c][13:12];
  endfunction

  function automatic logic [1:0] src_ctl(int c);
    return ctl_word[c][8:7];
  endfunction

  function automatic logic [1:0] dst_ctl(int c);
    return ctl_word[c][6:5];
  endfunction

  function automatic int unsigned count_of(int c);
    int unsigned n;
    n = (c == 3) ? cnt_start[c] : (cnt_start[c] & 16'h3FFF);
    if (n == 0) n = (c == 3) ? 32'h10000 : 32'h4000;
    return n;
  endfunction

  function automatic void rescan_immediate();
    imm_flag = 0;
    for (int c = 0; c < ChannelCount; c++)
      if (ctl_word[c][15] && timing(c) == 2'd0) imm_flag = 1;
  endfunction

  function automatic logic [31:0] next_addr(logic [31:0] a, logic [1:0] ctl, int unsigned sz);
    if (ctl == STEP_DEC) return a - sz;
    if (ctl == STEP_FIXED) return a;
    return a + sz;
  endfunction

  function automatic void shut_channel(int c);
    ctl_word[c] = ctl_word[c] & ~ENABLE_BIT;
    units_left[c] = 0;
    armed[c] = MODE_IDLE;
    burst_pos[c] = 0;
    rescan_immediate();
  endfunction

  function automatic void apply_control(int c, logic [15:0] v);
    bit was_en;
    bit was_imm;
    logic [15:0] m;
    was_en = ctl_word[c][15];
    was_imm = was_en && timing(c) == 2'd0;
    m = CTL_MASK;
    if (c == 3) m = m | DRQ_BIT;
    ctl_word[c] = v & m;
    if (!was_en && ctl_word[c][15]) begin
      src_now[c] = src_start[c];
      dst_now[c] = dst_start[c];
      units_left[c] = count_of(c);
    end
    if (!ctl_word[c][15]) begin
      units_left[c] = 0;
      armed[c] = MODE_IDLE;
      burst_pos[c] = 0;
    end
    if (ctl_word[c][15] && timing(c) == 2'd0) imm_flag = 1;
    else if (was_imm) rescan_immediate();
  endfunction

  function automatic bit fire_trigger(logic [2:0] kind);
    logic [31:0] fa;
    if (kind <= TRIG_SPEC) begin
      for (int c = 0; c < ChannelCount; c++) begin
        if (!ctl_word[c][15] || timing(c) != kind[1:0] || armed[c] != MODE_IDLE) continue;
        if (src_ctl(c) == STEP_RELOAD) begin
          if (kind == TRIG_IMM) imm_flag = 1;
          return 1;
        end
        armed[c] = MODE_MEM;
      end
      return 0;
    end
    if (kind <= TRIG_FIFOB) begin
      fa = (kind == TRIG_FIFOB) ? FIFO_B_ADDR : FIFO_A_ADDR;
      for (int c = 1; c <= 2 && c < ChannelCount; c++) begin
        if (!ctl_word[c][15] || timing(c) != 2'd3 || dst_start[c] != fa ||
            armed[c] != MODE_IDLE) continue;
        if (!(ctl_word[c] & WORD_BIT) || src_ctl(c) == STEP_RELOAD ||
            dst_ctl(c) != STEP_FIXED) return 1;
        armed[c] = (kind == TRIG_FIFOB) ? MODE_FIFOB : MODE_FIFOA;
        burst_pos[c] = 0;
      end
      return 0;
    end
    return 1;
  endfunction

  function automatic void advance_unit(ref out_item_t r);
    int ch;
    int unsigned sz;
    int unsigned rem;
    logic [31:0] smask;
    logic [31:0] dmask;
    logic [31:0] ra;
    logic [1:0] sctl;
    bit word;
    bit irq;
    bit fb;
    ch = 4;
    for (int c = ChannelCount - 1; c >= 0; c--) if (armed[c] != MODE_IDLE) ch = c;
    if (ch == 4) return;
    smask = (ch == 0) ? ADDR27_MASK : ADDR28_MASK;
    word = (ctl_word[ch] & WORD_BIT) != 0;
    irq = (ctl_word[ch] & IRQ_BIT) != 0;
    r.transfer_valid = 1;
    r.out_channel = ch[1:0];
    if (armed[ch] == MODE_MEM) begin
      sz = word ? 4 : 2;
      dmask = (ch == 3) ? ADDR28_MASK : ADDR27_MASK;
      // game pak rom source always counts up on channels 1 to 3
      sctl = (ch != 0 && src_now[ch][27:24] >= 4'h8 && src_now[ch][27:24] <= 4'hD)
             ? STEP_INC : src_ctl(ch);
      ra = (src_now[ch] & smask) & ~(sz - 1);
      r.read_address = ra[27:0];
      r.write_address = (dst_now[ch] & dmask) & ~(sz - 1);
      r.word_unit = word;
      src_now[ch] = next_addr(src_now[ch], sctl, sz);
      dst_now[ch] = next_addr(dst_now[ch], dst_ctl(ch), sz);
      units_left[ch] = units_left[ch] > 1 ? units_left[ch] - 1 : 0;
      if (units_left[ch] == 0) begin
        r.last_unit = 1;
        r.irq_request = irq;
        if ((ctl_word[ch] & REPEAT_BIT) && timing(ch) != 2'd0) begin
          units_left[ch] = count_of(ch);
          if (dst_ctl(ch) == STEP_RELOAD) dst_now[ch] = dst_start[ch];
          armed[ch] = MODE_IDLE;
        end else begin
          shut_channel(ch);
        end
      end
    end else begin
      fb = armed[ch] == MODE_FIFOB;
      ra = (src_now[ch] & smask) & ~32'd3;
      r.read_address = ra[27:0];
      r.write_address = fb ? FIFO_B_ADDR : FIFO_A_ADDR;
      r.word_unit = 1;
      r.fifo_target = fb ? 2'd2 : 2'd1;
      src_now[ch] = next_addr(src_now[ch], src_ctl(ch), 4);
      burst_pos[ch]++;
      if (burst_pos[ch] >= FifoBurstWords) begin
        rem = units_left[ch] >= FifoBurstWords ? units_left[ch] - FifoBurstWords : 0;
        r.last_unit = 1;
        dst_now[ch] = dst_start[ch];
        armed[ch] = MODE_IDLE;
        burst_pos[ch] = 0;
        if (rem != 0) begin
          units_left[ch] = rem;
        end else begin
          r.irq_request = irq;
          if (ctl_word[ch] & REPEAT_BIT) units_left[ch] = count_of(ch);
          else shut_channel(ch);
        end
      end
    end
  endfunction

  function automatic bit predict_unit(in_item_t it, ref out_item_t r);
    int c;
    c = it.channel;
    r = '0;
    if (it.command <= CMD_CTL && c >= ChannelCount) return 0;
    case (it.command)
      CMD_SRC: begin
        src_start[c] = it.write_data;
        return 0;
      end
      CMD_DST: begin
        dst_start[c] = it.write_data;
        return 0;
      end
      CMD_CNT: begin
        cnt_start[c] = it.write_data[15:0];
        return 0;
      end
      CMD_CTL: apply_control(c, it.write_data[15:0]);
      CMD_TRIG: r.unsupported = fire_trigger(it.trigger_kind);
      CMD_ADV: advance_unit(r);
      default: return 0;
    endcase
    r.imm_waiting = imm_flag;
    return 1;
  endfunction

  function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endfunction

  out_item_t predicted;
  out_item_t oldest;

  initial begin
    errors = 0;
    pending = 0;
    for (int c = 0; c < 4; c++) begin
      src_start[c] = 0; dst_start[c] = 0; cnt_start[c] = 0; ctl_word[c] = 0;
      src_now[c] = 0; dst_now[c] = 0; units_left[c] = 0; armed[c] = MODE_IDLE;
      burst_pos[c] = 0;
    end
    imm_flag = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (predict_unit(in_item, predicted)) expected_units.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (expected_units.size() == 0) begin
          $display("%0t unexpected item: expected none actual %h", $time, out_item);
          errors++;
        end else begin
          oldest = expected_units.pop_front();
          check_field("transfer_valid", oldest.transfer_valid, out_item.transfer_valid);
          check_field("out_channel", oldest.out_channel, out_item.out_channel);
          check_field("read_address", oldest.read_address, out_item.read_address);
          check_field("write_address", oldest.write_address, out_item.write_address);
          check_field("word_unit", oldest.word_unit, out_item.word_unit);
          check_field("last_unit", oldest.last_unit, out_item.last_unit);
          check_field("irq_request", oldest.irq_request, out_item.irq_request);
          check_field("unsupported", oldest.unsupported, out_item.unsupported);
          check_field("fifo_target", oldest.fifo_target, out_item.fifo_target);
          check_field("imm_waiting", oldest.imm_waiting, out_item.imm_waiting);
        end
      end
      pending = expected_units.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
module tb
  import fcds_pkg::*;
();

  localparam logic [2:0] TRIG_VBL  = 3'd1;
  localparam logic [2:0] TRIG_HBL  = 3'd2;
  localparam logic [2:0] TRIG_BAD6 = 3'd6;
  localparam logic [2:0] TRIG_BAD7 = 3'd7;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  int        errors;
  int        pending;
  int        sent;
  int        burst_left;
  int        stall_left;
  bit        stall_mode;

  four_channel_dma_sequencer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  fcds_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .errors(errors), .pending(pending)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver alternates runs of ready and stalls, sometimes a long run of either
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= ($urandom_range(0, 2) == 0);
      stall_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 6);
      out_ready <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
      out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  task automatic send(in_item_t it);
    logic rdy;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    sent++;
  endtask

  task automatic put(cmd_t cmd, int c, logic [31:0] data, logic [2:0] kind);
    in_item_t it;
    it.command = cmd;
    it.channel = c[1:0];
    it.write_data = data;
    it.trigger_kind = kind;
    send(it);
  endtask

  task automatic dma_sequence();
    int c;
    bit fifo;
    bit big;
    logic [31:0] s;
    logic [31:0] d;
    logic [15:0] ctl;
    logic [2:0] kind;
    c = $urandom_range(0, 3);
    fifo = (c == 1 || c == 2) && $urandom_range(0, 2) == 0;
    big = $urandom_range(0, 40) == 0;
    s = $urandom;
    if ($urandom_range(0, 2) == 0) s[27:24] = 4'($urandom_range(8, 13));
    d = $urandom;
    if (fifo) d = $urandom_range(0, 1) ? FIFO_B_ADDR : FIFO_A_ADDR;
    ctl = 16'($urandom);
    ctl[15] = 1'b1;
    if (fifo) begin
      ctl[13:12] = 2'd3;
      if ($urandom_range(0, 4) != 0) begin
        ctl[10] = 1'b1;
        ctl[6:5] = STEP_FIXED;
      end
    end
    if ($urandom_range(0, 4) != 0 && ctl[8:7] == STEP_RELOAD) ctl[8:7] = STEP_INC;
    put(CMD_SRC, c, s, 3'($urandom));
    put(CMD_DST, c, d, 3'($urandom));
    put(CMD_CNT, c, big ? $urandom : {16'($urandom), 16'(0)} | 32'($urandom_range(1, 6)),
        3'($urandom));
    put(CMD_CTL, c, $urandom & 32'hFFFF7FFF, 3'($urandom));
    put(CMD_CTL, c, {$urandom & 32'hFFFF0000} | ctl, 3'($urandom));
    repeat ($urandom_range(1, 3)) begin
      if (fifo) kind = (d == FIFO_B_ADDR) ? TRIG_FIFOB : TRIG_FIFOA;
      else kind = {1'b0, ctl[13:12]};
      if ($urandom_range(0, 7) == 0) kind = 3'($urandom);
      put(CMD_TRIG, $urandom, $urandom, kind);
      repeat ($urandom_range(1, 9)) put(CMD_ADV, $urandom, $urandom, 3'($urandom));
    end
    if (big || $urandom_range(0, 3) == 0) put(CMD_CTL, c, 32'h0, 3'($urandom));
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    in_item = '0;
    out_ready = 0;
    sent = 0;
    burst_left = 0;
    stall_left = 0;
    stall_mode = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reserved commands, bad triggers, advance with nothing armed
    put(CMD_RSV6, 0, 32'hFFFFFFFF, 3'd7);
    put(CMD_RSV7, 3, 32'h0, 3'd0);
    put(CMD_TRIG, 0, 32'h0, TRIG_BAD6);
    put(CMD_TRIG, 0, 32'h0, TRIG_BAD7);
    put(CMD_ADV, 0, 32'h0, 3'd0);
    // channel 0 extremes, immediate timing, reload source unsupported
    put(CMD_SRC, 0, 32'hFFFFFFFF, 3'd0);
    put(CMD_DST, 0, 32'hFFFFFFFF, 3'd0);
    put(CMD_CNT, 0, 32'hFFFF0002, 3'd0);
    put(CMD_CTL, 0, 32'hFFFF8180, 3'd0);
    put(CMD_TRIG, 0, 32'h0, TRIG_IMM);
    put(CMD_CTL, 0, 32'h0000C420, 3'd0);
    put(CMD_TRIG, 0, 32'h0, TRIG_IMM);
    put(CMD_ADV, 0, 32'h0, 3'd0);
    put(CMD_ADV, 0, 32'h0, 3'd0);
    // channel 3 with drq bit, game pak source, special timing repeat, zero count
    put(CMD_SRC, 3, 32'h08000001, 3'd0);
    put(CMD_CNT, 3, 32'h0, 3'd0);
    put(CMD_CTL, 3, 32'h0000FFE0 & ~32'h0180 | 32'h0100, 3'd0);
    put(CMD_TRIG, 3, 32'h0, TRIG_SPEC);
    put(CMD_ADV, 3, 32'h0, 3'd0);
    put(CMD_CTL, 3, 32'h0, 3'd0);
    // fifo trigger on channel 1 with a bad fifo setting, then vblank and hblank triggers
    put(CMD_DST, 1, FIFO_A_ADDR, 3'd0);
    put(CMD_CTL, 1, 32'h0000B000, 3'd0);
    put(CMD_TRIG, 1, 32'h0, TRIG_FIFOA);
    put(CMD_TRIG, 1, 32'h0, TRIG_VBL);
    put(CMD_TRIG, 1, 32'h0, TRIG_HBL);

    while (sent < 650) begin
      if ($urandom_range(0, 4) == 0)
        put(cmd_t'(3'($urandom)), $urandom, $urandom, 3'($urandom));
      else dma_sequence();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** four_channel_dma_sequencer: PASSED **");
    end else begin
      $display("** four_channel_dma_sequencer: FAILED **");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("** four_channel_dma_sequencer: FAILED **");
    $finish;
  end

endmodule
